// ===== sv/atcr_pkg.sv =====
// Shared types and constants for the clock replacement table.
package atcr_pkg;

    localparam int unsigned ENTRIES_DEF  = 64;
    localparam int unsigned KEY_BITS_DEF = 32;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned SLOT_W       = 6;
    localparam int unsigned CNT_W        = 32;

    typedef enum logic [1:0] {
        KIND_GRAB   = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // Beat layouts, in the order of the block's fields.
    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic               ref_mark;
        logic [SLOT_W-1:0]  slot_in;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic               is_new;
        logic [SLOT_W-1:0]  slot_out;
        logic               error;
        logic [CNT_W-1:0]   lookup_count;
        logic [CNT_W-1:0]   hit_count;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture input beat, start match
        logic commit;    // apply the lookup result / pop / remove
        logic sweep;     // advance the hand one slot, clear its reference bit
        logic finish;    // install after sweep, build result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_grab_miss_full; // grab missed and free stack empty
        logic sweep_done;        // slot after the hand has clear reference bit
    } t_sts;

endpackage

// ===== sv/atcr_if.sv =====
// Valid/ready channel carrying a typed payload.
interface atcr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/atcr_ctrl.sv =====
// Sequencer for the clock replacement table.
module atcr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  atcr_pkg::t_sts   i_sts,
    output atcr_pkg::t_cmd   o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MATCH = 5'b00010,
        S_SWEEP = 5'b00100,
        S_FIN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                if (i_sts.is_grab_miss_full) begin
                    n_state = S_SWEEP;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped");
    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP && i_sts.sweep_done |=> r_state == S_FIN)
        else $error("sweep did not finish");
endmodule

// ===== sv/atcr_dp.sv =====
// Key store, flags, free stack, clock hand and counters.
module atcr_dp #(
    parameter int unsigned ENTRIES  = atcr_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BITS = atcr_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  atcr_pkg::t_cmd              i_cmd,
    output atcr_pkg::t_sts              o_sts,
    input  logic [1:0]                  i_kind,
    input  logic [atcr_pkg::KEY_W-1:0]  i_key,
    input  logic                        i_ref_mark,
    input  logic [atcr_pkg::SLOT_W-1:0] i_slot_in,
    output logic                        o_hit,
    output logic                        o_is_new,
    output logic [atcr_pkg::SLOT_W-1:0] o_slot_out,
    output logic                        o_error,
    output logic [atcr_pkg::CNT_W-1:0]  o_lookup_count,
    output logic [atcr_pkg::CNT_W-1:0]  o_hit_count
);
    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned DW = $clog2(ENTRIES + 1);
    localparam int unsigned KW = (KEY_BITS < atcr_pkg::KEY_W) ? KEY_BITS : atcr_pkg::KEY_W;

    logic [KW-1:0]      r_keys [ENTRIES];
    logic [ENTRIES-1:0] r_used, r_ref;
    logic [IW-1:0]      r_stack [ENTRIES];
    logic [IW-1:0]      r_stack_q;  // registered read at the stack top
    logic [DW-1:0]      r_depth;
    logic [DW-1:0]      r_low;      // lowest depth since reset; entries below keep reset order
    logic [IW-1:0]      r_hand;
    logic [atcr_pkg::CNT_W-1:0] r_lookups, r_hits;

    logic [1:0]    r_kind;
    logic [KW-1:0] r_key;
    logic          r_mark;
    logic [atcr_pkg::SLOT_W-1:0] r_slot;
    logic          r_hit, r_new, r_err;
    logic [IW-1:0] r_sout;

    // parallel compare, lowest match wins
    logic          c_match;
    logic [IW-1:0] c_midx;
    always_comb begin
        c_match = 1'b0;
        c_midx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_used[i] && r_keys[i] == r_key) begin
                c_match = 1'b1;
                c_midx  = IW'(i);
            end
        end
    end

    logic [IW-1:0] c_next;
    assign c_next = (r_hand == IW'(ENTRIES - 1)) ? '0 : r_hand + 1'b1;

    logic          c_slot_ok;
    logic [IW-1:0] c_sidx;
    assign c_slot_ok = ({26'd0, r_slot} < 32'(ENTRIES));
    assign c_sidx    = IW'(r_slot);

    // stack top: entries never pushed since reset read as their reset order
    logic [DW-1:0] c_dm1;
    logic [IW-1:0] c_tidx;
    logic [IW-1:0] c_top;
    logic          c_push;
    assign c_dm1  = r_depth - 1'b1;
    assign c_tidx = c_dm1[IW-1:0];
    assign c_top  = (DW'(c_tidx) < r_low) ? IW'(ENTRIES - 1) - c_tidx : r_stack_q;
    assign c_push = i_cmd.commit && r_kind == atcr_pkg::KIND_REMOVE && c_slot_ok &&
                    r_used[c_sidx] && r_depth < DW'(ENTRIES);

    assign o_sts.is_grab_miss_full = (r_kind == atcr_pkg::KIND_GRAB) && !c_match && r_depth == '0;
    assign o_sts.sweep_done        = !r_ref[c_next];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= KW'(i_key);
            r_mark <= i_ref_mark;
            r_slot <= i_slot_in;
        end
        if (i_cmd.commit && r_kind == atcr_pkg::KIND_GRAB && !c_match) begin
            r_keys[c_top] <= r_key;
        end
        if (i_cmd.finish) r_keys[r_hand] <= r_key;
        if (c_push) r_stack[r_depth[IW-1:0]] <= c_sidx;
        r_stack_q <= r_stack[c_tidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_ref     <= '0;
            r_depth   <= DW'(ENTRIES);
            r_low     <= DW'(ENTRIES);
            r_hand    <= IW'(ENTRIES - 1);
            r_lookups <= '0;
            r_hits    <= '0;
            r_hit     <= 1'b0;
            r_new     <= 1'b0;
            r_err     <= 1'b0;
            r_sout    <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_hit  <= 1'b0;
                r_new  <= 1'b0;
                r_err  <= 1'b0;
                r_sout <= '0;
                case (r_kind)
                    atcr_pkg::KIND_GRAB: begin
                        r_lookups <= r_lookups + 1'b1;
                        if (c_match) begin
                            r_hit         <= 1'b1;
                            r_hits        <= r_hits + 1'b1;
                            r_ref[c_midx] <= 1'b1;
                            r_sout        <= c_midx;
                        end else begin
                            // pop the free stack
                            r_new   <= 1'b1;
                            r_depth <= c_dm1;
                            if (c_dm1 < r_low) r_low <= c_dm1;
                            r_sout  <= c_top;
                            r_used[c_top] <= 1'b1;
                            r_ref[c_top]  <= 1'b1;
                        end
                    end
                    atcr_pkg::KIND_FIND: begin
                        r_lookups <= r_lookups + 1'b1;
                        if (c_match) begin
                            r_hit  <= 1'b1;
                            r_hits <= r_hits + 1'b1;
                            r_sout <= c_midx;
                            if (r_mark) r_ref[c_midx] <= 1'b1;
                        end
                    end
                    atcr_pkg::KIND_REMOVE: begin
                        if (!c_slot_ok || !r_used[c_sidx]) begin
                            r_err <= 1'b1;
                        end else begin
                            r_used[c_sidx] <= 1'b0;
                            if (r_depth < DW'(ENTRIES)) r_depth <= r_depth + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.sweep) begin
                r_hand <= c_next;
                if (r_ref[c_next]) r_ref[c_next] <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_lookups     <= r_lookups + 1'b1;
                r_hit         <= 1'b0;
                r_new         <= 1'b0;
                r_err         <= 1'b0;
                r_sout        <= r_hand;
                r_used[r_hand] <= 1'b1;
                r_ref[r_hand]  <= 1'b1;
            end
        end
    end

    assign o_hit          = r_hit;
    assign o_is_new       = r_new;
    assign o_slot_out     = atcr_pkg::SLOT_W'(r_sout);
    assign o_error        = r_err;
    assign o_lookup_count = r_lookups;
    assign o_hit_count    = r_hits;

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_depth <= DW'(ENTRIES))
        else $error("free depth overflow");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_kind == atcr_pkg::KIND_GRAB && !c_match |-> r_depth != '0)
        else $error("pop from empty stack");
    a_full_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep |-> r_used == '1 && r_depth == '0)
        else $error("sweep with free slots");
endmodule

// ===== sv/assoc_table_clock_replace.sv =====
// Clock (second-chance) replacement table top level.
// Timing: hit, find, remove and grab-from-free-stack go from the input beat through
// the match state to the result beat; a grab that evicts first sweeps, moving the hand
// one slot at a time to a clear reference bit, and then installs there.
// Throughput: one item at a time, next input taken the cycle after the result.
// Reset (synchronous, i_rst_n low): flags cleared, hand at last slot, free stack full.
module assoc_table_clock_replace #(
    parameter int unsigned ENTRIES  = atcr_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BITS = atcr_pkg::KEY_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    atcr_if.sink   i_req,
    atcr_if.source o_rsp
);
    atcr_pkg::t_cmd cmd;
    atcr_pkg::t_sts sts;

    // Sequencer: take a beat, match, optionally sweep, hold the result.
    atcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: table state and result registers.
    atcr_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_req.data.kind),
        .i_key          (i_req.data.key),
        .i_ref_mark     (i_req.data.ref_mark),
        .i_slot_in      (i_req.data.slot_in),
        .o_hit          (o_rsp.data.hit),
        .o_is_new       (o_rsp.data.is_new),
        .o_slot_out     (o_rsp.data.slot_out),
        .o_error        (o_rsp.data.error),
        .o_lookup_count (o_rsp.data.lookup_count),
        .o_hit_count    (o_rsp.data.hit_count)
    );
endmodule

// ===== sim/tb_assoc_table_clock_replace.sv =====
// Self-checking testbench for the clock replacement table: directed table, then random traffic.
module tb_assoc_table_clock_replace;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NSLOT      = atcr_pkg::ENTRIES_DEF;
    localparam int unsigned RAND_ITEMS = 1030;
    localparam int unsigned IDLE_LIMIT = 2000;

    localparam atcr_pkg::t_kind K_GRAB   = atcr_pkg::KIND_GRAB;
    localparam atcr_pkg::t_kind K_FIND   = atcr_pkg::KIND_FIND;
    localparam atcr_pkg::t_kind K_REMOVE = atcr_pkg::KIND_REMOVE;
    localparam atcr_pkg::t_kind K_NONE   = atcr_pkg::KIND_NONE;

    // One row of the directed table; fixed rows carry a hand-written answer.
    typedef struct {
        atcr_pkg::t_req req;
        bit             fixed;
        atcr_pkg::t_rsp want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    atcr_if #(.T(atcr_pkg::t_req)) req_ch ();
    atcr_if #(.T(atcr_pkg::t_rsp)) rsp_ch ();

    assoc_table_clock_replace dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the table state.
    logic [atcr_pkg::KEY_W-1:0]  tbl_key   [NSLOT];
    bit                          tbl_used  [NSLOT];
    bit                          tbl_ref   [NSLOT];
    int unsigned                 hand;
    int unsigned                 free_list [NSLOT];
    int unsigned                 free_cnt;
    logic [atcr_pkg::CNT_W-1:0]  n_lookups;
    logic [atcr_pkg::CNT_W-1:0]  n_hits;

    atcr_pkg::t_rsp pending_rsp[$];
    int unsigned err_cnt    = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_grab = 0, n_find = 0, n_remove = 0, n_evict = 0, n_bad_remove = 0;
    bit          calm_rx = 1'b0;
    bit          calm_tx = 1'b0;

    function automatic void table_clear();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_key[i]   = '0;
            tbl_used[i]  = 1'b0;
            tbl_ref[i]   = 1'b0;
            free_list[i] = NSLOT - 1 - i;
        end
        hand      = NSLOT - 1;
        free_cnt  = NSLOT;
        n_lookups = '0;
        n_hits    = '0;
    endfunction

    function automatic int match_slot(logic [atcr_pkg::KEY_W-1:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_used[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    // Apply one beat to the shadow table and return the answer it must give.
    function automatic atcr_pkg::t_rsp table_apply(atcr_pkg::t_req r);
        atcr_pkg::t_rsp o;
        int   s;
        int unsigned p;
        o = '0;
        case (r.kind)
            K_GRAB: begin
                n_grab++;
                n_lookups++;
                s = match_slot(r.key);
                if (s >= 0) begin
                    o.hit = 1'b1;
                    n_hits++;
                end else begin
                    if (free_cnt > 0) begin
                        free_cnt--;
                        s = free_list[free_cnt];
                        o.is_new = 1'b1;
                    end else begin
                        // second chance: clear set bits until a clear one turns up
                        n_evict++;
                        p = (hand + 1) % NSLOT;
                        while (tbl_ref[p]) begin
                            tbl_ref[p] = 1'b0;
                            p = (p + 1) % NSLOT;
                        end
                        hand = p;
                        s = p;
                    end
                    tbl_key[s]  = r.key;
                    tbl_used[s] = 1'b1;
                end
                tbl_ref[s] = 1'b1;
                o.slot_out = s[atcr_pkg::SLOT_W-1:0];
            end
            K_FIND: begin
                n_find++;
                n_lookups++;
                s = match_slot(r.key);
                if (s >= 0) begin
                    o.hit = 1'b1;
                    n_hits++;
                    if (r.ref_mark) tbl_ref[s] = 1'b1;
                    o.slot_out = s[atcr_pkg::SLOT_W-1:0];
                end
            end
            K_REMOVE: begin
                n_remove++;
                if (!tbl_used[r.slot_in]) begin
                    o.error = 1'b1;
                    n_bad_remove++;
                end else begin
                    tbl_used[r.slot_in] = 1'b0;
                    free_list[free_cnt] = r.slot_in;
                    free_cnt++;
                end
            end
            default: ;
        endcase
        o.lookup_count = n_lookups;
        o.hit_count    = n_hits;
        return o;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long pause.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic atcr_pkg::t_req mk_req(atcr_pkg::t_kind k,
                                              logic [atcr_pkg::KEY_W-1:0] key, logic m,
                                              int unsigned s);
        atcr_pkg::t_req r;
        r.kind     = k;
        r.key      = key;
        r.ref_mark = m;
        r.slot_in  = s[atcr_pkg::SLOT_W-1:0];
        return r;
    endfunction

    function automatic atcr_pkg::t_rsp mk_rsp(bit h, bit nw, int unsigned s, bit e,
                                              int unsigned lc, int unsigned hc);
        atcr_pkg::t_rsp o;
        o.hit          = h;
        o.is_new       = nw;
        o.slot_out     = s[atcr_pkg::SLOT_W-1:0];
        o.error        = e;
        o.lookup_count = lc;
        o.hit_count    = hc;
        return o;
    endfunction

    // Send one beat: hold valid low for a gap, then hold the beat until taken.
    task automatic send_beat(atcr_pkg::t_req r, bit fixed, atcr_pkg::t_rsp want);
        atcr_pkg::t_rsp got;
        int unsigned gap;
        gap = pick_gap(calm_tx);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        got = table_apply(r);
        if (fixed) begin
            if (got !== want) begin
                $error("table row disagrees with shadow table: row %h shadow %h", want, got);
                err_cnt++;
            end
            pending_rsp.push_back(want);
        end else begin
            pending_rsp.push_back(got);
        end
    endtask

    // Random beat: mostly grabs, over a key pool whose size decides hits versus evictions.
    function automatic atcr_pkg::t_req rand_req(int unsigned pool);
        int unsigned r;
        logic [atcr_pkg::KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        k = (r % 7 == 0) ? atcr_pkg::KEY_W'($urandom()) :
            atcr_pkg::KEY_W'($urandom_range(0, pool - 1) * 32'h9E3779B1);
        if (r < 72) return mk_req(K_GRAB, k, 1'($urandom()), $urandom_range(0, 63));
        if (r < 87) return mk_req(K_FIND, k, 1'($urandom()), $urandom_range(0, 63));
        if (r < 98) return mk_req(K_REMOVE, k, 1'($urandom()), $urandom_range(0, 63));
        return mk_req(K_NONE, k, 1'($urandom()), $urandom_range(0, 63));
    endfunction

    // Response side: stall at random, compare every accepted beat.
    always @(posedge i_clk) begin
        atcr_pkg::t_rsp want;
        atcr_pkg::t_rsp got;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= (pick_gap(calm_rx) == 0);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                if (pending_rsp.size() == 0) begin
                    $error("result beat with nothing expected: %h", got);
                    err_cnt++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d actual %0d", want.hit, got.hit);
                        err_cnt++;
                    end
                    if (got.is_new !== want.is_new) begin
                        $error("is_new: expected %0d actual %0d", want.is_new, got.is_new);
                        err_cnt++;
                    end
                    if (got.slot_out !== want.slot_out) begin
                        $error("slot_out: expected %0d actual %0d", want.slot_out, got.slot_out);
                        err_cnt++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %0d actual %0d", want.error, got.error);
                        err_cnt++;
                    end
                    if (got.lookup_count !== want.lookup_count) begin
                        $error("lookup_count: expected %0d actual %0d",
                               want.lookup_count, got.lookup_count);
                        err_cnt++;
                    end
                    if (got.hit_count !== want.hit_count) begin
                        $error("hit_count: expected %0d actual %0d",
                               want.hit_count, got.hit_count);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        int unsigned pool;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        table_clear();

        // Directed rows: empty table, extreme keys, every kind, free-stack reuse.
        rows.push_back('{mk_req(K_FIND, 32'h0, 1'b1, 0), 1, mk_rsp(0, 0, 0, 0, 1, 0)});
        rows.push_back('{mk_req(K_REMOVE, 32'h0, 1'b0, 63), 1, mk_rsp(0, 0, 0, 1, 1, 0)});
        rows.push_back('{mk_req(K_NONE, 32'hFFFFFFFF, 1'b1, 63), 1, mk_rsp(0, 0, 0, 0, 1, 0)});
        rows.push_back('{mk_req(K_GRAB, 32'h0, 1'b0, 0), 1, mk_rsp(0, 1, 0, 0, 2, 0)});
        rows.push_back('{mk_req(K_GRAB, 32'hFFFFFFFF, 1'b1, 63), 1, mk_rsp(0, 1, 1, 0, 3, 0)});
        rows.push_back('{mk_req(K_GRAB, 32'h0, 1'b1, 5), 1, mk_rsp(1, 0, 0, 0, 4, 1)});
        rows.push_back('{mk_req(K_FIND, 32'hFFFFFFFF, 1'b0, 0), 1, mk_rsp(1, 0, 1, 0, 5, 2)});
        rows.push_back('{mk_req(K_FIND, 32'hFFFFFFFF, 1'b1, 0), 1, mk_rsp(1, 0, 1, 0, 6, 3)});
        rows.push_back('{mk_req(K_FIND, 32'h80000000, 1'b1, 0), 1, mk_rsp(0, 0, 0, 0, 7, 3)});
        rows.push_back('{mk_req(K_REMOVE, 32'h0, 1'b0, 0), 1, mk_rsp(0, 0, 0, 0, 7, 3)});
        rows.push_back('{mk_req(K_REMOVE, 32'h0, 1'b0, 0), 1, mk_rsp(0, 0, 0, 1, 7, 3)});
        rows.push_back('{mk_req(K_GRAB, 32'h12345678, 1'b0, 0), 1, mk_rsp(0, 1, 0, 0, 8, 3)});
        rows.push_back('{mk_req(K_GRAB, 32'h0, 1'b0, 0), 0, '0});
        rows.push_back('{mk_req(K_FIND, 32'h12345678, 1'b0, 42), 0, '0});
        rows.push_back('{mk_req(K_REMOVE, 32'hFFFFFFFF, 1'b1, 1), 0, '0});
        rows.push_back('{mk_req(K_GRAB, 32'hFFFFFFFF, 1'b1, 21), 0, '0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_beat(rows[i].req, rows[i].fixed, rows[i].want);

        // Random traffic in phases: small pools hit in a part-filled table,
        // large pools fill it and drive the clock sweep.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                pool    = ((n / 100) % 3 == 0) ? 24 : 300;
                calm_tx = ($urandom_range(0, 3) == 0);
                calm_rx = ($urandom_range(0, 3) == 0);
            end
            send_beat(rand_req(pool), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Covered %0d grabs (%0d evictions), %0d finds, %0d removes (%0d rejected)",
                 n_grab, n_evict, n_find, n_remove, n_bad_remove);
        $display("Final lookup count %0d, hit count %0d", n_lookups, n_hits);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/atcr_pkg.sv
sv/atcr_if.sv
sv/atcr_ctrl.sv
sv/atcr_dp.sv
sv/assoc_table_clock_replace.sv
sim/tb_assoc_table_clock_replace.sv
